// ===== rtl/positional_list_store_unit_defines.svh =====
// Assertion macros for the positional list store; they expect i_clk and i_rst_n in scope.
`ifndef POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_STORE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PLS_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define PLS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define PLS_ASSERT(label, prop, msg)
`define PLS_ASSERT_IMPL(label, cond, prop, msg)
`define PLS_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

// ===== rtl/pls_pkg.sv =====
// Shared constants, codes and types of the positional list store.
package pls_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int POS_W     = 16;
    localparam int ENTRIES_W = 5;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_RD_FWD    = 3'd6,
        CMD_RD_BWD    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD = 3'd0,
        OP_INS  = 3'd1,
        OP_DEL  = 3'd2,
        OP_ROTF = 3'd3,
        OP_ROTB = 3'd4
    } t_op;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  k;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  count;
        logic [VAL_W-1:0]  head;
        logic [VAL_W-1:0]  tail;
    } t_cell_ctrl;

endpackage

// ===== rtl/pls_cell.sv =====
// One storage cell of the list chain; shifts toward either neighbor or loads a new value.
module pls_cell (
    input  logic                      i_clk,
    input  logic [pls_pkg::IDX_W-1:0] i_index,
    input  pls_pkg::t_cell_ctrl       i_ctrl,
    input  logic [pls_pkg::VAL_W-1:0] i_left,
    input  logic [pls_pkg::VAL_W-1:0] i_right,
    output logic [pls_pkg::VAL_W-1:0] o_value
);
    import pls_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic [CNT_W-1:0] idx_c;
    logic [CNT_W-1:0] tail_idx;

    assign idx_c    = CNT_W'(i_index);
    assign tail_idx = i_ctrl.count - CNT_W'(1);

    always_comb begin
        n_value = r_value;
        unique case (i_ctrl.op)
            OP_HOLD: n_value = r_value;
            OP_INS: begin
                if (i_index > i_ctrl.k) begin
                    n_value = i_left;
                end else if (i_index == i_ctrl.k) begin
                    n_value = i_ctrl.value;
                end
            end
            OP_DEL: begin
                if (i_index >= i_ctrl.k) begin
                    n_value = i_right;
                end
            end
            // Rotations run only over the occupied cells, so a full read restores the order.
            OP_ROTF: begin
                if (idx_c < tail_idx) begin
                    n_value = i_right;
                end else if (idx_c == tail_idx) begin
                    n_value = i_ctrl.head;
                end
            end
            OP_ROTB: begin
                if (idx_c == '0) begin
                    n_value = i_ctrl.tail;
                end else if (idx_c <= tail_idx) begin
                    n_value = i_left;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== rtl/positional_list_store_unit.sv =====
// Top level of the positional list store: command decode, read sequencer and cell chain.
//
//   channel | dir | tdata                               | tuser       | tlast
//   s       | in  | [31:0] value, [47:32] position      | [2:0] cmd   | -
//   m       | out | [31:0] element, [36:32] entries     | [1:0] status| last
//
// An insert or delete updates every cell in parallel, and the single result is
// registered for the next cycle. A read holds the input off until every element has
// gone out, one element per output transfer, while the chain rotates one place per element.
// A stall on the output pauses the rotation; the input is ready whenever no read runs
// and the output register is free or being drained. Reset empties the list at once.
`include "positional_list_store_unit_defines.svh"

module positional_list_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [31:0] value, [47:32] position
    input  logic [2:0]  i_s_tuser,   // [2:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] element, [36:32] entries, [39:37] zero
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast
);
    import pls_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_fwd, n_fwd;
    logic               r_m_valid, n_m_valid;
    t_status            r_status, n_status;
    logic [VAL_W-1:0]   r_element, n_element;
    logic [CNT_W-1:0]   r_entries, n_entries;
    logic               r_last, n_last;

    t_cell_ctrl         ctrl;
    logic [VAL_W-1:0]   cell_val [CAPACITY];
    logic [VAL_W-1:0]   tail_val;
    logic               out_free;
    logic               accept;
    t_cmd               cmd;
    logic [VAL_W-1:0]   in_value;
    logic [POS_W-1:0]   in_pos;

    assign cmd      = t_cmd'(i_s_tuser);
    assign in_value = i_s_tdata[31:0];
    assign in_pos   = i_s_tdata[47:32];
    assign out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept   = i_s_tvalid && o_s_tready;

    function automatic logic [IDX_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                   input logic [CNT_W-1:0] limit);
        logic [IDX_W-1:0] res;
        if (p[POS_W-1] || p == '0) begin
            res = '0;
        end else if (p > POS_W'(limit)) begin
            res = IDX_W'(limit);
        end else begin
            res = p[IDX_W-1:0];
        end
        return res;
    endfunction

    // The last occupied cell, picked by a gated OR across the chain.
    always_comb begin
        tail_val = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (CNT_W'(j) == r_count - CNT_W'(1)) begin
                tail_val = tail_val | cell_val[j];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_left    = r_left;
        n_fwd     = r_fwd;
        n_m_valid = r_m_valid && !i_m_tready;
        n_status  = r_status;
        n_element = r_element;
        n_entries = r_entries;
        n_last    = r_last;
        ctrl.op    = OP_HOLD;
        ctrl.k     = '0;
        ctrl.value = in_value;
        ctrl.count = r_count;
        ctrl.head  = cell_val[0];
        ctrl.tail  = tail_val;

        if (accept) begin
            n_m_valid = 1'b1;
            n_status  = STAT_OK;
            n_element = '0;
            n_last    = 1'b1;
            unique case (cmd)
                CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                    if (r_count == CNT_W'(CAPACITY)) begin
                        n_status = STAT_FULL;
                    end else begin
                        ctrl.op = OP_INS;
                        priority case (cmd)
                            CMD_INS_FRONT: ctrl.k = '0;
                            CMD_INS_BACK:  ctrl.k = IDX_W'(r_count);
                            default:       ctrl.k = clamp_pos(in_pos, r_count);
                        endcase
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        ctrl.op = OP_DEL;
                        priority case (cmd)
                            CMD_DEL_FRONT: ctrl.k = '0;
                            CMD_DEL_BACK:  ctrl.k = IDX_W'(r_count - CNT_W'(1));
                            default:       ctrl.k = clamp_pos(in_pos, r_count - CNT_W'(1));
                        endcase
                        n_count = r_count - CNT_W'(1);
                    end
                end
                CMD_RD_FWD, CMD_RD_BWD: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        n_m_valid = r_m_valid && !i_m_tready;
                        n_state   = S_READ;
                        n_left    = r_count;
                        n_fwd     = (cmd == CMD_RD_FWD);
                    end
                end
                default: n_status = STAT_OK;
            endcase
            n_entries = n_count;
        end else if (r_state == S_READ && out_free) begin
            n_m_valid = 1'b1;
            n_status  = STAT_OK;
            n_element = r_fwd ? cell_val[0] : tail_val;
            n_entries = r_count;
            n_last    = (r_left == CNT_W'(1));
            ctrl.op   = r_fwd ? OP_ROTF : OP_ROTB;
            n_left    = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = S_IDLE;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] right_v;
        if (g == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_val[g];
        end else begin : g_mid_r
            assign right_v = cell_val[g+1];
        end
        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (ctrl),
            .i_left  (left_v),
            .i_right (right_v),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd     <= n_fwd;
        r_status  <= n_status;
        r_element <= n_element;
        r_entries <= n_entries;
        r_last    <= n_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {3'b000, ENTRIES_W'(r_entries), r_element};
    assign o_m_tuser  = r_status;
    assign o_m_tlast  = r_last;

    `PLS_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "list count above capacity")
    `PLS_ASSERT_IMPL(a_read_left, r_state == S_READ, r_left != '0, "read run with nothing left")
    `PLS_ASSERT_NEXT(a_read_count, r_state == S_READ, r_count == $past(r_count),
                     "list count changed during a read run")
    `PLS_ASSERT_IMPL(a_ready_idle, o_s_tready, r_state == S_IDLE, "input ready during a read")

endmodule

// ===== tb/tb_positional_list_store_unit.sv =====
// Self-checking testbench for the positional list store: directed table, then random commands.
module tb_positional_list_store_unit;
    import pls_pkg::*;

    localparam int N_RANDOM   = 228;
    localparam int CALM_ITEMS = 50;    // random items at the end with no idling
    localparam int HOLD_AT    = 90;    // random item at which the long output stall begins
    localparam int HOLD_LEN   = 300;
    localparam int STALL_MAX  = 2000;  // cycles with no transfer on either side
    localparam int TAIL       = 24;

    typedef struct packed {
        t_status     status;
        logic [31:0] element;
        logic [4:0]  entries;
        logic        last;
    } t_list_result;

    // A row with check_fixed set carries its single result written out by hand.
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] value;
        logic [15:0] pos;
        logic [4:0]  repeats;
        logic        check_fixed;
        t_status     status;
        logic [4:0]  entries;
    } t_cmd_row;

    localparam int N_ROWS = 25;

    t_cmd_row directed_rows [N_ROWS] = '{
        '{CMD_RD_FWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_EMPTY, 5'd0},
        '{CMD_DEL_FRONT, 32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_EMPTY, 5'd0},
        '{CMD_DEL_BACK,  32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_EMPTY, 5'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 16'h0005, 5'd1,  1'b1, STAT_EMPTY, 5'd0},
        '{CMD_RD_BWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_EMPTY, 5'd0},
        '{CMD_INS_POS,   32'h1234_5678, 16'h0064, 5'd1,  1'b1, STAT_OK,    5'd1},
        '{CMD_DEL_POS,   32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_OK,    5'd0},
        '{CMD_INS_FRONT, 32'h7FFF_FFFF, 16'h0000, 5'd1,  1'b1, STAT_OK,    5'd1},
        '{CMD_INS_BACK,  32'h8000_0000, 16'h0000, 5'd1,  1'b1, STAT_OK,    5'd2},
        '{CMD_INS_POS,   32'h0000_0005, 16'h8000, 5'd1,  1'b1, STAT_OK,    5'd3},
        '{CMD_INS_POS,   32'hFFFF_FFFF, 16'h7FFF, 5'd1,  1'b1, STAT_OK,    5'd4},
        '{CMD_INS_POS,   32'hA5A5_A5A5, 16'h0002, 5'd1,  1'b1, STAT_OK,    5'd5},
        '{CMD_RD_FWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, STAT_OK,    5'd0},
        '{CMD_RD_BWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, STAT_OK,    5'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 16'h7FFF, 5'd1,  1'b1, STAT_OK,    5'd4},
        '{CMD_DEL_POS,   32'h0000_0000, 16'h0001, 5'd1,  1'b1, STAT_OK,    5'd3},
        '{CMD_DEL_BACK,  32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_OK,    5'd2},
        '{CMD_INS_BACK,  32'h5A5A_0000, 16'h0000, 5'd14, 1'b0, STAT_OK,    5'd0},
        '{CMD_INS_FRONT, 32'h0BAD_0001, 16'h0000, 5'd1,  1'b1, STAT_FULL,  5'd16},
        '{CMD_INS_POS,   32'h0000_0000, 16'h0003, 5'd1,  1'b1, STAT_FULL,  5'd16},
        '{CMD_RD_FWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, STAT_OK,    5'd0},
        '{CMD_RD_BWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b0, STAT_OK,    5'd0},
        '{CMD_DEL_POS,   32'h0000_0000, 16'hFFFF, 5'd1,  1'b1, STAT_OK,    5'd15},
        '{CMD_DEL_BACK,  32'h0000_0000, 16'h0000, 5'd16, 1'b0, STAT_OK,    5'd0},
        '{CMD_RD_FWD,    32'h0000_0000, 16'h0000, 5'd1,  1'b1, STAT_EMPTY, 5'd0}
    };

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        cmd_valid = 1'b0;
    logic [47:0] cmd_data  = '0;
    logic [2:0]  cmd_kind  = '0;
    logic        res_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    logic [31:0]  list_shadow[$];      // front at index 0
    t_list_result expected_results[$];
    int           n_fail     = 0;
    int           quiet_run  = 0;
    bit           calm       = 1'b0;
    bit           hold_req   = 1'b0;

    positional_list_store_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (cmd_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (cmd_data),
        .i_s_tuser  (cmd_kind),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (res_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_list_result make_result(t_status st, logic [31:0] el, int cnt,
                                                 logic last);
        t_list_result r;
        r.status  = st;
        r.element = el;
        r.entries = 5'(cnt);
        r.last    = last;
        return r;
    endfunction

    function automatic int clamp_slot(logic signed [15:0] p, int limit);
        if (p <= 0) return 0;
        if (int'(p) > limit) return limit;
        return int'(p);
    endfunction

    // Applies one command to the shadow list and returns the results it should produce.
    function automatic void predict_list_cmd(t_cmd cmd, logic [31:0] value,
                                             logic signed [15:0] pos,
                                             output t_list_result res[$]);
        int n;
        int k;
        res = {};
        n = list_shadow.size();
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
                if (n >= CAPACITY) begin
                    res.push_back(make_result(STAT_FULL, 32'd0, n, 1'b1));
                end else begin
                    if (cmd == CMD_INS_FRONT) k = 0;
                    else if (cmd == CMD_INS_BACK) k = n;
                    else k = clamp_slot(pos, n);
                    list_shadow.insert(k, value);
                    res.push_back(make_result(STAT_OK, 32'd0, n + 1, 1'b1));
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                if (n == 0) begin
                    res.push_back(make_result(STAT_EMPTY, 32'd0, 0, 1'b1));
                end else begin
                    if (cmd == CMD_DEL_FRONT) k = 0;
                    else if (cmd == CMD_DEL_BACK) k = n - 1;
                    else k = clamp_slot(pos, n - 1);
                    list_shadow.delete(k);
                    res.push_back(make_result(STAT_OK, 32'd0, n - 1, 1'b1));
                end
            end
            default: begin
                if (n == 0) begin
                    res.push_back(make_result(STAT_EMPTY, 32'd0, 0, 1'b1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        k = (cmd == CMD_RD_FWD) ? i : n - 1 - i;
                        res.push_back(make_result(STAT_OK, list_shadow[k], n, i == n - 1));
                    end
                end
            end
        endcase
    endfunction

    task automatic offer_cmd(input t_cmd cmd, input logic [31:0] value, input logic [15:0] pos,
                             input logic fixed, input t_status st, input int ent);
        t_list_result res[$];
        cmd_valid <= 1'b1;
        cmd_data  <= {pos, value};
        cmd_kind  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predict_list_cmd(cmd, value, pos, res);
        if (fixed) expected_results.push_back(make_result(st, 32'd0, ent, 1'b1));
        else foreach (res[i]) expected_results.push_back(res[i]);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(3) == 0) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge i_clk);
        end
    endtask

    // Command side: directed table, then random traffic, then drain and verdict.
    initial begin
        t_cmd        cmd;
        logic [31:0] value;
        logic [15:0] pos;
        int          sel;
        int          ins_weight;
        int          pick;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int j = 0; j < directed_rows[r].repeats; j++) begin
                offer_cmd(directed_rows[r].cmd, directed_rows[r].value + j,
                          directed_rows[r].pos, directed_rows[r].check_fixed,
                          directed_rows[r].status, directed_rows[r].entries);
                maybe_pause();
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == N_RANDOM - CALM_ITEMS) calm = 1'b1;
            // Alternate between filling and draining so both the full and empty ends are hit.
            ins_weight = ((n / 48) % 2 == 0) ? 55 : 25;
            sel = $urandom_range(99);
            if (sel < ins_weight) cmd = t_cmd'($urandom_range(2, 0));
            else if (sel < 80) cmd = t_cmd'($urandom_range(5, 3));
            else cmd = t_cmd'($urandom_range(7, 6));
            pick = $urandom_range(9);
            if (pick < 6) pos = 16'($urandom_range(18));
            else if (pick < 8) pos = 16'(-int'($urandom_range(3)));
            else pos = 16'($urandom);
            value = $urandom;
            offer_cmd(cmd, value, pos, 1'b0, STAT_OK, 0);
            maybe_pause();
        end
        cmd_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("[positional_list_store_unit] OK");
        end else begin
            $display("[positional_list_store_unit] ERROR");
        end
        $finish;
    end

    // Result side: random ready bursts, one long hold-off on request, steady at the end.
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (calm) begin
                res_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res_ready <= 1'b1;
                repeat ($urandom_range(40, 1)) @(posedge i_clk);
                if (!calm) begin
                    res_ready <= 1'b0;
                    repeat ($urandom_range(19, 1)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_m_tvalid && res_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: element %0d entries %0d",
                       $signed(o_m_tdata[31:0]), o_m_tdata[36:32]);
                n_fail++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_m_tuser != exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_m_tuser);
                    n_fail++;
                end
                if (o_m_tdata[31:0] != exp_r.element) begin
                    $error("element: expected %0d, got %0d", $signed(exp_r.element),
                           $signed(o_m_tdata[31:0]));
                    n_fail++;
                end
                if (o_m_tdata[36:32] != exp_r.entries) begin
                    $error("entries: expected %0d, got %0d", exp_r.entries, o_m_tdata[36:32]);
                    n_fail++;
                end
                if (o_m_tlast != exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_m_tlast);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_valid && o_s_tready) || (o_m_tvalid && res_ready)) begin
                quiet_run <= 0;
            end else if (quiet_run + 1 >= STALL_MAX) begin
                $display("[positional_list_store_unit] ERROR");
                $finish;
            end else begin
                quiet_run <= quiet_run + 1;
            end
        end
    end

endmodule
